/* src/cpot_pkg.sv */
// ----------------------------------------------------------------------------
// cpot_pkg: collider pair overlap test shared definitions
// Widths, operation and shape codes, pair classes and the queued job type.
// ----------------------------------------------------------------------------
package cpot_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int SCALE_WIDTH = 16;
  localparam int SCALE_FRAC  = 8;

  // offset + position
  localparam int POS_W  = COORD_WIDTH + 1;
  // size * scale
  localparam int EXT_W  = COORD_WIDTH + SCALE_WIDTH;
  // centre difference
  localparam int DIFF_W = POS_W + 1;
  // box-box corner sums, signed
  localparam int BB_W   = EXT_W + 2;
  // box-circle doubled domain, signed
  localparam int BC_W   = EXT_W + 2;
  // distance from circle centre to clamped point, unsigned
  localparam int DIST_W  = DIFF_W + SCALE_FRAC;
  localparam int DIST_LO = DIST_W / 2;
  localparam int DIST_HI = DIST_W - DIST_LO;
  localparam int RAD_W   = EXT_W;
  localparam int RAD_LO  = RAD_W / 2;
  localparam int RAD_HI  = RAD_W - RAD_LO;
  localparam int SQ_D_W  = 2 * DIST_W;
  localparam int SQ_R_W  = 2 * RAD_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_TEST     = 1'b1;
  localparam logic KIND_BOX    = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  // pair class; for PAIR_BC the box is always collider a
  localparam logic [1:0] PAIR_BB = 2'd0;
  localparam logic [1:0] PAIR_BC = 2'd1;
  localparam logic [1:0] PAIR_CC = 2'd2;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] ox;
    logic [COORD_WIDTH-1:0] oy;
    logic [COORD_WIDTH-1:0] sx;
    logic [COORD_WIDTH-1:0] sy;
    logic [COORD_WIDTH-1:0] px;
    logic [COORD_WIDTH-1:0] py;
    logic [SCALE_WIDTH-1:0] kx;
    logic [SCALE_WIDTH-1:0] ky;
  } coll_t;

  typedef struct packed {
    logic [1:0] pair;
    coll_t      a;
    coll_t      b;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

/* src/cpot_front.sv */
// ----------------------------------------------------------------------------
// cpot_front: input transaction acceptance and pair classification
// Holds collider A, takes loads, and queues classified test jobs.
// ----------------------------------------------------------------------------
module cpot_front import cpot_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic                          in_kind,
  input  logic signed [COORD_WIDTH-1:0] in_offset_x,
  input  logic signed [COORD_WIDTH-1:0] in_offset_y,
  input  logic        [COORD_WIDTH-1:0] in_size_x,
  input  logic        [COORD_WIDTH-1:0] in_size_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic        [SCALE_WIDTH-1:0] in_scale_x,
  input  logic        [SCALE_WIDTH-1:0] in_scale_y,
  input  logic                          q_full,
  output push_t                         q_wr
);

  coll_t held_r;
  logic  held_kind_r;
  coll_t cur_c;
  logic  accept_c;

  assign in_stall = q_full;
  assign accept_c = in_valid & ~q_full;

  assign cur_c = '{ox: in_offset_x, oy: in_offset_y, sx: in_size_x, sy: in_size_y,
                   px: in_pos_x, py: in_pos_y, kx: in_scale_x, ky: in_scale_y};

  // classify; a box facing a circle always goes first
  always_comb begin
    q_wr.push     = accept_c & (in_operation == OP_TEST);
    q_wr.job.a    = held_r;
    q_wr.job.b    = cur_c;
    q_wr.job.pair = PAIR_CC;
    if (held_kind_r == KIND_BOX && in_kind == KIND_BOX) begin
      q_wr.job.pair = PAIR_BB;
    end else if (held_kind_r == KIND_BOX) begin
      q_wr.job.pair = PAIR_BC;
    end else if (in_kind == KIND_BOX) begin
      q_wr.job.pair = PAIR_BC;
      q_wr.job.a    = cur_c;
      q_wr.job.b    = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      held_kind_r <= KIND_BOX;
    end else if (accept_c && in_operation == OP_LOAD) begin
      held_r      <= cur_c;
      held_kind_r <= in_kind;
    end
  end

endmodule

/* src/cpot_queue.sv */
// ----------------------------------------------------------------------------
// cpot_queue: job queue between front and back
// Small FIFO of classified test jobs; head is read directly.
// ----------------------------------------------------------------------------
module cpot_queue import cpot_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t wr,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output job_t  head
);

  job_t                q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] cnt_r;

  assign full  = (cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      q_mem_r[wr_ptr_r] <= wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (wr.push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !wr.push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push |-> !full)
    else $error("push into full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

/* src/cpot_back.sv */
// ----------------------------------------------------------------------------
// cpot_back: overlap evaluation pipeline
// Extents, clamp distances, split squares and final compare, then output reg.
// ----------------------------------------------------------------------------
module cpot_back import cpot_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  job_t head,
  input  logic q_empty,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic out_hit
);

  logic adv_c;

  // stage 1: centres, extents, radius
  logic signed [POS_W-1:0] pax_c, pay_c, pbx_c, pby_c;
  logic [EXT_W-1:0]        wa_c, ha_c, wb_c, hb_c;
  logic [COORD_WIDTH:0]    rcc_c;
  logic                    s1_v_r;
  logic [1:0]              s1_pair_r;
  logic signed [POS_W-1:0] s1_pax_r, s1_pay_r, s1_pbx_r, s1_pby_r;
  logic [EXT_W-1:0]        s1_wa_r, s1_ha_r, s1_wb_r, s1_hb_r;
  logic [RAD_W-1:0]        s1_rad_r;

  // stage 2: box-box verdict, distances
  logic signed [BB_W-1:0]   ax_c, ay_c, bx_c, by_c;
  logic signed [BB_W-1:0]   aw_c, ah_c, bw_c, bh_c;
  logic signed [BB_W-1:0]   axe_c, aye_c, bxe_c, bye_c;
  logic                     bbhit_c;
  logic signed [DIFF_W-1:0] dfx_c, dfy_c;
  logic [DIFF_W-1:0]        adx_c, ady_c;
  logic signed [BC_W-1:0]   tx_c, ty_c, d1x_c, d2x_c, d1y_c, d2y_c;
  logic [DIST_W-1:0]        distx_c, disty_c;
  logic                     s2_v_r, s2_bb_r, s2_bbhit_r;
  logic [DIST_W-1:0]        s2_dx_r, s2_dy_r;
  logic [RAD_W-1:0]         s2_rad_r;

  // stage 3: partial products
  logic                        s3_v_r, s3_bb_r, s3_bbhit_r;
  logic [2*DIST_HI-1:0]        s3_xhh_r, s3_yhh_r;
  logic [DIST_W-1:0]           s3_xhl_r, s3_yhl_r;
  logic [2*DIST_LO-1:0]        s3_xll_r, s3_yll_r;
  logic [2*RAD_HI-1:0]         s3_rhh_r;
  logic [RAD_W-1:0]            s3_rhl_r;
  logic [2*RAD_LO-1:0]         s3_rll_r;

  // stage 4: squares
  logic                s4_v_r, s4_bb_r, s4_bbhit_r;
  logic [SQ_D_W-1:0]   s4_sqx_r, s4_sqy_r;
  logic [SQ_R_W-1:0]   s4_sqr_r;
  logic [SQ_D_W:0]     dsum_c;

  logic out_valid_r, out_hit_r;

  assign adv_c     = ~out_valid_r | ~out_stall;
  assign pop       = adv_c & ~q_empty;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // ---- stage 1
  assign pax_c = $signed({head.a.ox[COORD_WIDTH-1], head.a.ox})
               + $signed({head.a.px[COORD_WIDTH-1], head.a.px});
  assign pay_c = $signed({head.a.oy[COORD_WIDTH-1], head.a.oy})
               + $signed({head.a.py[COORD_WIDTH-1], head.a.py});
  assign pbx_c = $signed({head.b.ox[COORD_WIDTH-1], head.b.ox})
               + $signed({head.b.px[COORD_WIDTH-1], head.b.px});
  assign pby_c = $signed({head.b.oy[COORD_WIDTH-1], head.b.oy})
               + $signed({head.b.py[COORD_WIDTH-1], head.b.py});
  assign wa_c  = head.a.sx * head.a.kx;
  assign ha_c  = head.a.sy * head.a.ky;
  assign wb_c  = head.b.sx * head.b.kx;
  assign hb_c  = head.b.sy * head.b.ky;
  assign rcc_c = {1'b0, head.a.sx} + {1'b0, head.b.sx};

  always_ff @(posedge clk) begin
    if (adv_c) begin
      s1_pair_r <= head.pair;
      s1_pax_r  <= pax_c;
      s1_pay_r  <= pay_c;
      s1_pbx_r  <= pbx_c;
      s1_pby_r  <= pby_c;
      s1_wa_r   <= wa_c;
      s1_ha_r   <= ha_c;
      s1_wb_r   <= wb_c;
      s1_hb_r   <= hb_c;
      // circle pairs use unscaled radii; box-circle the scaled circle size
      s1_rad_r  <= (head.pair == PAIR_CC) ? RAD_W'(rcc_c) : wb_c;
    end
  end

  // ---- stage 2
  assign ax_c = {{(BB_W-POS_W-SCALE_FRAC){s1_pax_r[POS_W-1]}}, s1_pax_r, {SCALE_FRAC{1'b0}}};
  assign ay_c = {{(BB_W-POS_W-SCALE_FRAC){s1_pay_r[POS_W-1]}}, s1_pay_r, {SCALE_FRAC{1'b0}}};
  assign bx_c = {{(BB_W-POS_W-SCALE_FRAC){s1_pbx_r[POS_W-1]}}, s1_pbx_r, {SCALE_FRAC{1'b0}}};
  assign by_c = {{(BB_W-POS_W-SCALE_FRAC){s1_pby_r[POS_W-1]}}, s1_pby_r, {SCALE_FRAC{1'b0}}};
  assign aw_c = {2'b00, s1_wa_r};
  assign ah_c = {2'b00, s1_ha_r};
  assign bw_c = {2'b00, s1_wb_r};
  assign bh_c = {2'b00, s1_hb_r};
  assign axe_c = ax_c + aw_c;
  assign aye_c = ay_c + ah_c;
  assign bxe_c = bx_c + bw_c;
  assign bye_c = by_c + bh_c;
  // closed intervals, touching counts
  assign bbhit_c = (axe_c >= bx_c) && (bxe_c >= ax_c) && (aye_c >= by_c) && (bye_c >= ay_c);

  assign dfx_c = {s1_pax_r[POS_W-1], s1_pax_r} - {s1_pbx_r[POS_W-1], s1_pbx_r};
  assign dfy_c = {s1_pay_r[POS_W-1], s1_pay_r} - {s1_pby_r[POS_W-1], s1_pby_r};
  assign adx_c = dfx_c[DIFF_W-1] ? -dfx_c : dfx_c;
  assign ady_c = dfy_c[DIFF_W-1] ? -dfy_c : dfy_c;

  // doubled domain: centre difference times 2^(SCALE_FRAC+1); half-extent is size*scale
  assign tx_c  = {{(BC_W-DIFF_W-SCALE_FRAC-1){dfx_c[DIFF_W-1]}}, dfx_c, {(SCALE_FRAC+1){1'b0}}};
  assign ty_c  = {{(BC_W-DIFF_W-SCALE_FRAC-1){dfy_c[DIFF_W-1]}}, dfy_c, {(SCALE_FRAC+1){1'b0}}};
  assign d1x_c = tx_c - $signed({2'b00, s1_wa_r});
  assign d2x_c = -tx_c - $signed({2'b00, s1_wa_r});
  assign d1y_c = ty_c - $signed({2'b00, s1_ha_r});
  assign d2y_c = -ty_c - $signed({2'b00, s1_ha_r});

  always_comb begin
    distx_c = '0;
    disty_c = '0;
    case (s1_pair_r)
      PAIR_BC: begin
        // outside the box on one side at most; inside gives zero
        if (!d1x_c[BC_W-1] && d1x_c != '0) begin
          distx_c = d1x_c[DIST_W-1:0];
        end else if (!d2x_c[BC_W-1] && d2x_c != '0) begin
          distx_c = d2x_c[DIST_W-1:0];
        end
        if (!d1y_c[BC_W-1] && d1y_c != '0) begin
          disty_c = d1y_c[DIST_W-1:0];
        end else if (!d2y_c[BC_W-1] && d2y_c != '0) begin
          disty_c = d2y_c[DIST_W-1:0];
        end
      end
      PAIR_CC: begin
        distx_c = DIST_W'(adx_c);
        disty_c = DIST_W'(ady_c);
      end
      default: begin
        distx_c = '0;
        disty_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      s2_bb_r    <= (s1_pair_r == PAIR_BB);
      s2_bbhit_r <= bbhit_c;
      s2_dx_r    <= distx_c;
      s2_dy_r    <= disty_c;
      s2_rad_r   <= s1_rad_r;
    end
  end

  // ---- stage 3: split squares into half-width products
  always_ff @(posedge clk) begin
    if (adv_c) begin
      s3_bb_r    <= s2_bb_r;
      s3_bbhit_r <= s2_bbhit_r;
      s3_xhh_r   <= s2_dx_r[DIST_W-1:DIST_LO] * s2_dx_r[DIST_W-1:DIST_LO];
      s3_xhl_r   <= s2_dx_r[DIST_W-1:DIST_LO] * s2_dx_r[DIST_LO-1:0];
      s3_xll_r   <= s2_dx_r[DIST_LO-1:0] * s2_dx_r[DIST_LO-1:0];
      s3_yhh_r   <= s2_dy_r[DIST_W-1:DIST_LO] * s2_dy_r[DIST_W-1:DIST_LO];
      s3_yhl_r   <= s2_dy_r[DIST_W-1:DIST_LO] * s2_dy_r[DIST_LO-1:0];
      s3_yll_r   <= s2_dy_r[DIST_LO-1:0] * s2_dy_r[DIST_LO-1:0];
      s3_rhh_r   <= s2_rad_r[RAD_W-1:RAD_LO] * s2_rad_r[RAD_W-1:RAD_LO];
      s3_rhl_r   <= s2_rad_r[RAD_W-1:RAD_LO] * s2_rad_r[RAD_LO-1:0];
      s3_rll_r   <= s2_rad_r[RAD_LO-1:0] * s2_rad_r[RAD_LO-1:0];
    end
  end

  // ---- stage 4: reassemble
  always_ff @(posedge clk) begin
    if (adv_c) begin
      s4_bb_r    <= s3_bb_r;
      s4_bbhit_r <= s3_bbhit_r;
      s4_sqx_r   <= (SQ_D_W'(s3_xhh_r) << (2*DIST_LO)) + (SQ_D_W'(s3_xhl_r) << (DIST_LO+1))
                  + SQ_D_W'(s3_xll_r);
      s4_sqy_r   <= (SQ_D_W'(s3_yhh_r) << (2*DIST_LO)) + (SQ_D_W'(s3_yhl_r) << (DIST_LO+1))
                  + SQ_D_W'(s3_yll_r);
      s4_sqr_r   <= (SQ_R_W'(s3_rhh_r) << (2*RAD_LO)) + (SQ_R_W'(s3_rhl_r) << (RAD_LO+1))
                  + SQ_R_W'(s3_rll_r);
    end
  end

  // ---- output register
  assign dsum_c = {1'b0, s4_sqx_r} + {1'b0, s4_sqy_r};

  always_ff @(posedge clk) begin
    if (adv_c) begin
      out_hit_r <= s4_bb_r ? s4_bbhit_r : (SQ_R_W'(dsum_c) <= s4_sqr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv_c) begin
      s1_v_r      <= ~q_empty;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> s1_v_r)
    else $error("popped job lost before stage 1");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_c |=> $stable(s4_v_r) && $stable(s1_v_r))
    else $error("pipeline moved while output blocked");

  a_s4_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && adv_c) |=> out_valid_r)
    else $error("finished job not presented");

endmodule

/* src/collider_pair_overlap_test_top.sv */
// ----------------------------------------------------------------------------
// collider_pair_overlap_test_top: held collider versus streamed collider test
// Front takes transactions, a short queue decouples it from the evaluator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): in_operation = 0 loads collider A (box or circle,
//   offset, size, position, scale) and yields no result; in_operation = 1
//   tests the supplied collider B against the held A and yields one hit.
//   A transaction is taken on a clock edge with in_valid high and in_stall low.
//   Result channel (out_*): out_hit is offered with out_valid and held until
//   the edge where out_stall is low.
//   Throughput: one transaction per cycle, sustained, while results drain.
//   Path: an accepted test is written into the queue, then passes the stages
//   (extents, clamp distances, split squares, reassembly, then
//   the squared-distance compare into the output register).
//   The squares are split into half-width partial products, and the
//   evaluator is a five-deep pipeline; multiplies sit in the extents and split-squares stages.
//   Stalls: out_stall on an offered result freezes the evaluator; the
//   four-entry queue keeps taking tests until it fills, then in_stall rises.
//   Loads never wait on the evaluator, they only need the queue not to be full.
//   Reset (rst_n low, synchronous): queue and pipeline empty, held collider
//   becomes a zero-sized box at the origin.
// ----------------------------------------------------------------------------
module collider_pair_overlap_test_top import cpot_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic                          in_kind,
  input  logic signed [COORD_WIDTH-1:0] in_offset_x,
  input  logic signed [COORD_WIDTH-1:0] in_offset_y,
  input  logic        [COORD_WIDTH-1:0] in_size_x,
  input  logic        [COORD_WIDTH-1:0] in_size_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic        [SCALE_WIDTH-1:0] in_scale_x,
  input  logic        [SCALE_WIDTH-1:0] in_scale_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit
);

  push_t q_wr;     // classified test job from the front
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  job_t  q_head;

  // front: holds collider A, orders box before circle
  cpot_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_kind      (in_kind),
    .in_offset_x  (in_offset_x),
    .in_offset_y  (in_offset_y),
    .in_size_x    (in_size_x),
    .in_size_y    (in_size_y),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_scale_x   (in_scale_x),
    .in_scale_y   (in_scale_y),
    .q_full       (q_full),
    .q_wr         (q_wr)
  );

  // decoupling queue
  cpot_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // evaluator pipeline and output register
  cpot_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hit   (out_hit)
  );

endmodule
